// File: design/assert_macros.svh
// assertion macros used by the particle push design file
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check that is switched off while reset is held
`define PPT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that holds at every edge, reset included
`define PPT_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPT_ASSERT(lbl, clk, rst_n, prop, msg)
`define PPT_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// File: design/ppt_pkg.sv
// shared constants, register codes and types of the particle push block
// no dependencies
package ppt_pkg;

    // fixed field widths
    localparam int DATA_W     = 32;
    localparam int DT_W       = 24;
    localparam int CELL_W     = 12;
    localparam int CFG_IDX_W  = 3;

    // acceleration store
    localparam int STORE_DEPTH = 4096;
    localparam int ST_AW       = $clog2(STORE_DEPTH);

    // parameter defaults
    localparam int GRID_DIM_DEF  = 16;
    localparam int FRAC_BITS_DEF = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_X_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_X_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_Y_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_Y_HIGH = 3'd4;

    // register reset values
    localparam logic [DT_W-1:0]   TIME_STEP_RST    = 24'd655;
    localparam logic [DATA_W-1:0] BOUND_X_LOW_RST  = 32'd0;
    localparam logic [DATA_W-1:0] BOUND_X_HIGH_RST = 32'd983040;
    localparam logic [DATA_W-1:0] BOUND_Y_LOW_RST  = 32'd0;
    localparam logic [DATA_W-1:0] BOUND_Y_HIGH_RST = 32'd983040;

    // enables of the two stages of one interpolation unit
    typedef struct packed {
        logic en_mul;
        logic en_add;
    } t_lerp_ctl;

endpackage

// File: design/ppt_lerp.sv
// two-stage linear interpolation a + round((b - a) * f) on 32-bit values
// depends on ppt_pkg
module ppt_lerp #(
    parameter int FRAC_BITS = ppt_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  ppt_pkg::t_lerp_ctl                i_ctl,
    input  logic signed [ppt_pkg::DATA_W-1:0] i_a,
    input  logic signed [ppt_pkg::DATA_W-1:0] i_b,
    input  logic        [FRAC_BITS:0]         i_frac,
    output logic signed [ppt_pkg::DATA_W-1:0] o_y
);
    import ppt_pkg::*;

    localparam int PW = DATA_W + 1 + FRAC_BITS + 2;
    localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

    logic signed [DATA_W:0]   diff;
    logic signed [PW-1:0]     r_prod;
    logic signed [DATA_W-1:0] r_a;
    logic signed [PW-1:0]     rnd;
    logic signed [DATA_W+1:0] rnd_n;
    logic signed [DATA_W+1:0] n_y;
    logic signed [DATA_W-1:0] r_y;

    // difference times fraction
    assign diff = (DATA_W+1)'(i_b) - (DATA_W+1)'(i_a);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mul) begin
            r_prod <= PW'(diff) * PW'($signed({1'b0, i_frac}));
            r_a    <= i_a;
        end
    end

    // round to nearest, ties up, then add base; result stays between a and b
    assign rnd   = (r_prod + HALF) >>> FRAC_BITS;
    assign rnd_n = rnd[DATA_W+1:0];
    assign n_y   = (DATA_W+2)'(r_a) + rnd_n;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_add) begin
            r_y <= n_y[DATA_W-1:0];
        end
    end

    assign o_y = r_y;

endmodule

// File: design/particle_push_trilinear_field.sv
// One particle per beat. Every stage moves independently, so a new beat is taken each cycle
// while the first stage can move; o_stall rises only when all 15 stages are full and the
// output is stalled. A mode 0 beat writes one cell into the acceleration store from the
// address stage and gives no result. The store is kept as eight copies so the eight corner
// cells are read together; the corner read, three interpolation levels and the
// velocity/position multiplies each take their own stages.
// depends on ppt_pkg, ppt_lerp and assert_macros.svh
`include "assert_macros.svh"

module particle_push_trilinear_field #(
    parameter int GRID_DIM  = ppt_pkg::GRID_DIM_DEF,
    parameter int FRAC_BITS = ppt_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ppt_pkg::DATA_W-1:0]           i_cfg_data,
    // input channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_mode,
    input  logic [ppt_pkg::CELL_W-1:0]           i_cell_index,
    input  logic signed [ppt_pkg::DATA_W-1:0]    i_field_ax,
    input  logic signed [ppt_pkg::DATA_W-1:0]    i_field_ay,
    input  logic signed [ppt_pkg::DATA_W-1:0]    i_field_az,
    input  logic signed [ppt_pkg::DATA_W-1:0]    i_pos_in_x,
    input  logic signed [ppt_pkg::DATA_W-1:0]    i_pos_in_y,
    input  logic signed [ppt_pkg::DATA_W-1:0]    i_pos_in_z,
    input  logic signed [ppt_pkg::DATA_W-1:0]    i_vel_in_x,
    input  logic signed [ppt_pkg::DATA_W-1:0]    i_vel_in_y,
    input  logic signed [ppt_pkg::DATA_W-1:0]    i_vel_in_z,
    input  logic                                 i_alive_in,
    // output channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [ppt_pkg::DATA_W-1:0]    o_pos_out_x,
    output logic signed [ppt_pkg::DATA_W-1:0]    o_pos_out_y,
    output logic signed [ppt_pkg::DATA_W-1:0]    o_pos_out_z,
    output logic signed [ppt_pkg::DATA_W-1:0]    o_vel_out_x,
    output logic signed [ppt_pkg::DATA_W-1:0]    o_vel_out_y,
    output logic signed [ppt_pkg::DATA_W-1:0]    o_vel_out_z,
    output logic                                 o_alive_out
);
    import ppt_pkg::*;

    // stage numbers
    localparam int NS       = 15;
    localparam int ST_SPLIT = 1;
    localparam int ST_ADDR  = 2;
    localparam int ST_READ  = 3;
    localparam int ST_XMUL  = 4;
    localparam int ST_XADD  = 5;
    localparam int ST_YMUL  = 6;
    localparam int ST_YADD  = 7;
    localparam int ST_ZMUL  = 8;
    localparam int ST_ZADD  = 9;
    localparam int ST_ADT   = 10;
    localparam int ST_VN    = 11;
    localparam int ST_VSUM  = 12;
    localparam int ST_SDT   = 13;
    localparam int ST_PN    = 14;

    // grid geometry
    localparam int IW    = $clog2(GRID_DIM);
    localparam int DD    = GRID_DIM * GRID_DIM;
    localparam int CAW   = $clog2(GRID_DIM * GRID_DIM * GRID_DIM);
    localparam int EAW   = (CAW + 1 > ST_AW + 1) ? CAW + 1 : ST_AW + 1;
    localparam int unsigned CELLS = GRID_DIM * GRID_DIM * GRID_DIM;
    localparam logic signed [DATA_W-1:0] IMAX = DATA_W'(GRID_DIM - 2);
    localparam logic signed [DATA_W+1:0] ONE  = (DATA_W+2)'(1) << FRAC_BITS;

    // arithmetic widths
    localparam int AD_W  = DATA_W + DT_W + 1;
    localparam int SD_W  = DATA_W + 1 + DT_W + 1;
    localparam int SAT_W = SD_W + 1;
    localparam logic signed [AD_W-1:0]  HALF_A = AD_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [SD_W-1:0]  HALF_P = SD_W'(1) << FRAC_BITS;
    localparam logic signed [SAT_W-1:0] SMAX   = SAT_W'(32'sh7fffffff);
    localparam logic signed [SAT_W-1:0] SMIN   = SAT_W'($signed(32'h80000000));

    typedef struct packed {
        logic                     push;
        logic                     wr_ok;
        logic [CELL_W-1:0]        cidx;
        logic [2:0][DATA_W-1:0]   fa;
        logic [2:0][IW-1:0]       idx;
    } t_front;

    typedef struct packed {
        logic [2:0][DATA_W-1:0]   p;
        logic [2:0][DATA_W-1:0]   v;
        logic [2:0][DATA_W-1:0]   vn;
        logic [2:0][FRAC_BITS:0]  f;
        logic                     alive;
    } t_carry;

    function automatic logic [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
        logic [DATA_W-1:0] y;
        if (x > SMAX) begin
            y = SMAX[DATA_W-1:0];
        end else if (x < SMIN) begin
            y = SMIN[DATA_W-1:0];
        end else begin
            y = x[DATA_W-1:0];
        end
        return y;
    endfunction

    // configuration registers
    logic [DT_W-1:0]          r_time_step;
    logic signed [DATA_W-1:0] r_bx_lo, r_bx_hi, r_by_lo, r_by_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= TIME_STEP_RST;
            r_bx_lo     <= BOUND_X_LOW_RST;
            r_bx_hi     <= BOUND_X_HIGH_RST;
            r_by_lo     <= BOUND_Y_LOW_RST;
            r_by_hi     <= BOUND_Y_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TIME_STEP:    r_time_step <= i_cfg_data[DT_W-1:0];
                REG_BOUND_X_LOW:  r_bx_lo     <= i_cfg_data;
                REG_BOUND_X_HIGH: r_bx_hi     <= i_cfg_data;
                REG_BOUND_Y_LOW:  r_by_lo     <= i_cfg_data;
                REG_BOUND_Y_HIGH: r_by_hi     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [DT_W:0] dts;
    assign dts = $signed({1'b0, r_time_step});

    // stage enables: a stage moves unless the output is stalled and it and every stage after it are full
    logic [NS:1] r_v;
    logic [NS:1] en;

    for (genvar k = 1; k <= NS; k++) begin : g_en
        assign en[k] = !(i_stall && (&r_v[NS:k]));
    end

    assign o_stall = !en[1];

    // front stage registers
    t_front r_f1, r_f2;

    // valid bits; write beats drop out after the address stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_valid;
            end
            if (en[2]) begin
                r_v[2] <= r_v[1];
            end
            if (en[3]) begin
                r_v[3] <= r_v[2] && r_f2.push;
            end
            for (int k = 4; k <= NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // split position into clamped cell index and fraction
    logic [2:0][DATA_W-1:0] in_p;
    t_front                 n_f1;
    t_carry                 n_c1;

    assign in_p = {i_pos_in_z, i_pos_in_y, i_pos_in_x};

    always_comb begin
        logic signed [DATA_W-1:0] ip;
        logic signed [DATA_W-1:0] ci;
        logic signed [DATA_W+1:0] fw;
        logic signed [DATA_W+1:0] fc;
        n_f1.push  = i_mode;
        n_f1.wr_ok = (DATA_W'(i_cell_index) < CELLS);
        n_f1.cidx  = i_cell_index;
        n_f1.fa    = {i_field_az, i_field_ay, i_field_ax};
        n_c1.p     = in_p;
        n_c1.v     = {i_vel_in_z, i_vel_in_y, i_vel_in_x};
        n_c1.vn    = '0;
        n_c1.alive = i_alive_in;
        for (int a = 0; a < 3; a++) begin
            ip = $signed(in_p[a]) >>> FRAC_BITS;
            if (ip < 0) begin
                ci = '0;
            end else if (ip > IMAX) begin
                ci = IMAX;
            end else begin
                ci = ip;
            end
            fw = (DATA_W+2)'($signed(in_p[a])) - ((DATA_W+2)'(ci) <<< FRAC_BITS);
            if (fw < 0) begin
                fc = '0;
            end else if (fw > ONE) begin
                fc = ONE;
            end else begin
                fc = fw;
            end
            n_f1.idx[a] = ci[IW-1:0];
            n_c1.f[a]   = fc[FRAC_BITS:0];
        end
    end

    // front stages and carried particle data
    t_carry r_c [1:NS-1];
    t_carry n_c [2:NS-1];

    always_ff @(posedge i_clk) begin
        if (en[ST_SPLIT]) begin
            r_f1    <= n_f1;
            r_c[1]  <= n_c1;
        end
        if (en[ST_ADDR]) begin
            r_f2 <= r_f1;
        end
    end

    // corner addresses, eight cells around the particle
    logic [EAW-1:0]       base;
    logic [7:0][EAW-1:0]  caddr;
    logic [7:0][ST_AW-1:0] r_raddr;
    logic [7:0]           r_oob2;

    assign base = EAW'(r_f1.idx[0]) * EAW'(DD) + EAW'(r_f1.idx[1]) * EAW'(GRID_DIM)
                + EAW'(r_f1.idx[2]);

    for (genvar k = 0; k < 8; k++) begin : g_addr
        localparam int OFF = (k % 2) * DD + ((k / 2) % 2) * GRID_DIM + (k / 4);
        assign caddr[k] = base + EAW'(OFF);
        always_ff @(posedge i_clk) begin
            if (en[ST_ADDR]) begin
                r_raddr[k] <= caddr[k][ST_AW-1:0];
                r_oob2[k]  <= (caddr[k] >= EAW'(STORE_DEPTH));
            end
        end
    end

    // acceleration store, one copy per corner; writes and reads in pipeline order
    logic                      wr_en;
    logic [3*DATA_W-1:0]       wr_data;
    logic [7:0][3*DATA_W-1:0]  r_rd;
    logic [7:0]                r_oob3;

    assign wr_en   = en[3] && r_v[2] && !r_f2.push && r_f2.wr_ok;
    assign wr_data = r_f2.fa;

    for (genvar k = 0; k < 8; k++) begin : g_store
        logic [3*DATA_W-1:0] r_store [STORE_DEPTH];
        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                r_store[r_f2.cidx] <= wr_data;
            end
            if (en[3]) begin
                r_rd[k]   <= r_store[r_raddr[k]];
                r_oob3[k] <= r_oob2[k];
            end
        end
    end

    // trilinear interpolation: along x, then y, then z
    t_lerp_ctl ctl_x, ctl_y, ctl_z;
    logic signed [DATA_W-1:0] lx [3][4];
    logic signed [DATA_W-1:0] ly [3][2];
    logic signed [DATA_W-1:0] lz [3];
    logic signed [DATA_W-1:0] cv [3][8];

    assign ctl_x = '{en_mul: en[ST_XMUL], en_add: en[ST_XADD]};
    assign ctl_y = '{en_mul: en[ST_YMUL], en_add: en[ST_YADD]};
    assign ctl_z = '{en_mul: en[ST_ZMUL], en_add: en[ST_ZADD]};

    for (genvar c = 0; c < 3; c++) begin : g_comp
        for (genvar k = 0; k < 8; k++) begin : g_cv
            assign cv[c][k] = r_oob3[k] ? '0 : $signed(r_rd[k][c*DATA_W +: DATA_W]);
        end
        for (genvar j = 0; j < 4; j++) begin : g_lx
            ppt_lerp #(.FRAC_BITS(FRAC_BITS)) u_lx (
                .i_clk  (i_clk),
                .i_ctl  (ctl_x),
                .i_a    (cv[c][2*j]),
                .i_b    (cv[c][2*j+1]),
                .i_frac (r_c[ST_READ].f[0]),
                .o_y    (lx[c][j])
            );
        end
        for (genvar j = 0; j < 2; j++) begin : g_ly
            ppt_lerp #(.FRAC_BITS(FRAC_BITS)) u_ly (
                .i_clk  (i_clk),
                .i_ctl  (ctl_y),
                .i_a    (lx[c][2*j]),
                .i_b    (lx[c][2*j+1]),
                .i_frac (r_c[ST_XADD].f[1]),
                .o_y    (ly[c][j])
            );
        end
        ppt_lerp #(.FRAC_BITS(FRAC_BITS)) u_lz (
            .i_clk  (i_clk),
            .i_ctl  (ctl_z),
            .i_a    (ly[c][0]),
            .i_b    (ly[c][1]),
            .i_frac (r_c[ST_YADD].f[2]),
            .o_y    (lz[c])
        );
    end

    // acceleration times dt
    logic signed [AD_W-1:0] r_ad [3];

    always_ff @(posedge i_clk) begin
        if (en[ST_ADT]) begin
            for (int c = 0; c < 3; c++) begin
                r_ad[c] <= AD_W'(lz[c]) * AD_W'(dts);
            end
        end
    end

    // new velocity, saturated, merged into the carried data
    always_comb begin
        logic signed [AD_W-1:0] rad;
        for (int k = 2; k < NS; k++) begin
            n_c[k] = r_c[k-1];
        end
        for (int c = 0; c < 3; c++) begin
            rad = (r_ad[c] + HALF_A) >>> FRAC_BITS;
            n_c[ST_VN].vn[c] = sat32(SAT_W'($signed(r_c[ST_ADT].v[c])) + SAT_W'(rad));
        end
    end

    for (genvar k = 2; k < NS; k++) begin : g_carry
        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_c[k] <= n_c[k];
            end
        end
    end

    // old plus new velocity, times dt, then position
    logic signed [DATA_W:0]  r_sv [3];
    logic signed [SD_W-1:0]  r_sd [3];
    logic signed [SAT_W-1:0] r_pn [3];

    always_ff @(posedge i_clk) begin
        if (en[ST_VSUM]) begin
            for (int c = 0; c < 3; c++) begin
                r_sv[c] <= (DATA_W+1)'($signed(r_c[ST_VN].v[c]))
                         + (DATA_W+1)'($signed(r_c[ST_VN].vn[c]));
            end
        end
        if (en[ST_SDT]) begin
            for (int c = 0; c < 3; c++) begin
                r_sd[c] <= SD_W'(r_sv[c]) * SD_W'(dts);
            end
        end
        if (en[ST_PN]) begin
            for (int c = 0; c < 3; c++) begin
                r_pn[c] <= SAT_W'($signed(r_c[ST_SDT].p[c]))
                         + SAT_W'((r_sd[c] + HALF_P) >>> (FRAC_BITS + 1));
            end
        end
    end

    // bounds test and result select
    logic                   inb;
    logic                   keep;
    logic [2:0][DATA_W-1:0] n_pos, n_vel;
    logic [2:0][DATA_W-1:0] r_pos, r_vel;
    logic                   r_alive;

    assign inb  = (r_pn[0] >= SAT_W'(r_bx_lo)) && (r_pn[0] <= SAT_W'(r_bx_hi))
               && (r_pn[1] >= SAT_W'(r_by_lo)) && (r_pn[1] <= SAT_W'(r_by_hi));
    assign keep = r_c[ST_PN].alive && inb;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_pos[c] = keep ? sat32(r_pn[c]) : r_c[ST_PN].p[c];
            n_vel[c] = r_c[ST_PN].alive ? r_c[ST_PN].vn[c] : r_c[ST_PN].v[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NS]) begin
            r_pos   <= n_pos;
            r_vel   <= n_vel;
            r_alive <= keep;
        end
    end

    assign o_valid     = r_v[NS];
    assign o_pos_out_x = r_pos[0];
    assign o_pos_out_y = r_pos[1];
    assign o_pos_out_z = r_pos[2];
    assign o_vel_out_x = r_vel[0];
    assign o_vel_out_y = r_vel[1];
    assign o_vel_out_z = r_vel[2];
    assign o_alive_out = r_alive;

    // checks
    logic wr_leave;
    logic zadd_held;
    logic idx_ok;

    assign wr_leave  = r_v[2] && !r_f2.push && en[3];
    assign zadd_held = r_v[ST_ZADD] && !en[ST_ZADD];
    assign idx_ok    = (r_f1.idx[0] <= IW'(GRID_DIM - 2)) && (r_f1.idx[1] <= IW'(GRID_DIM - 2))
                    && (r_f1.idx[2] <= IW'(GRID_DIM - 2));

    `PPT_ASSERT(a_write_no_result, i_clk, i_rst_n, wr_leave |=> !r_v[3], "write beat kept")
    `PPT_ASSERT(a_held_stage_keeps, i_clk, i_rst_n, zadd_held |=> r_v[ST_ZADD], "beat lost")
    `PPT_ASSERT_NR(a_stall_only_full, i_clk, o_stall |-> (i_stall && (&r_v)), "early stall")
    `PPT_ASSERT(a_idx_clamped, i_clk, i_rst_n, (r_v[1] && r_f1.push) |-> idx_ok, "index off grid")

endmodule

// File: dv/tb_particle_push_trilinear_field.sv
// self-checking testbench of particle_push_trilinear_field: field fill, directed and random pushes
// a scoreboard class predicts each push beat's result; depends on ppt_pkg and the design files
`default_nettype none

module tb_particle_push_trilinear_field;
    timeunit 1ns;
    timeprecision 1ps;
    import ppt_pkg::*;

    localparam int GD = GRID_DIM_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_PUSH  = 1'b1;
    localparam int INT_MAX = 32'h7fffffff;
    localparam int INT_MIN = 32'h80000000;
    localparam int ONE = 1 << FB;
    // cell planes per axis that pushes can reach; filled before the first push
    localparam int FILL_IX [6] = '{0, 1, 2, GD - 3, GD - 2, GD - 1};

    typedef struct {
        logic mode;
        logic [CELL_W-1:0] cidx;
        int ax, ay, az;
        int px, py, pz;
        int vx, vy, vz;
        logic alive;
    } beat_t;

    typedef struct {
        int px, py, pz;
        int vx, vy, vz;
        logic alive;
    } particle_t;

    // predicts one leapfrog step per push beat and checks results in order
    class push_scoreboard;
        int acc_x[STORE_DEPTH];
        int acc_y[STORE_DEPTH];
        int acc_z[STORE_DEPTH];
        longint dt;
        longint xlo, xhi, ylo, yhi;
        particle_t pending[$];
        int errors;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] d);
            case (idx)
                REG_TIME_STEP:    dt = longint'(d[DT_W-1:0]);
                REG_BOUND_X_LOW:  xlo = longint'(signed'(d));
                REG_BOUND_X_HIGH: xhi = longint'(signed'(d));
                REG_BOUND_Y_LOW:  ylo = longint'(signed'(d));
                REG_BOUND_Y_HIGH: yhi = longint'(signed'(d));
                default: ;
            endcase
        endfunction

        function longint rnd_shift(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function longint sat(longint v);
            if (v > INT_MAX) return INT_MAX;
            if (v < INT_MIN) return INT_MIN;
            return v;
        endfunction

        function longint blend(longint a, longint b, longint f);
            return a + rnd_shift((b - a) * f, FB);
        endfunction

        function longint cell_at(int comp, int x, int y, int z);
            int addr;
            addr = (x * GD + y) * GD + z;
            if (addr >= STORE_DEPTH) return 0;
            case (comp)
                0: return acc_x[addr];
                1: return acc_y[addr];
                default: return acc_z[addr];
            endcase
        endfunction

        function longint interp(int comp, int ix[3], longint f[3]);
            longint c00, c10, c01, c11, c0, c1;
            c00 = blend(cell_at(comp, ix[0], ix[1], ix[2]),
                        cell_at(comp, ix[0]+1, ix[1], ix[2]), f[0]);
            c10 = blend(cell_at(comp, ix[0], ix[1]+1, ix[2]),
                        cell_at(comp, ix[0]+1, ix[1]+1, ix[2]), f[0]);
            c01 = blend(cell_at(comp, ix[0], ix[1], ix[2]+1),
                        cell_at(comp, ix[0]+1, ix[1], ix[2]+1), f[0]);
            c11 = blend(cell_at(comp, ix[0], ix[1]+1, ix[2]+1),
                        cell_at(comp, ix[0]+1, ix[1]+1, ix[2]+1), f[0]);
            c0 = blend(c00, c10, f[1]);
            c1 = blend(c01, c11, f[1]);
            return blend(c0, c1, f[2]);
        endfunction

        function void note(beat_t b);
            longint p[3], v[3], vn[3], pn[3], f[3], a, i;
            int ix[3];
            bit ok;
            particle_t r;
            // field write, cells beyond the grid are dropped
            if (b.mode == MODE_WRITE) begin
                if (b.cidx < GD * GD * GD) begin
                    acc_x[b.cidx] = b.ax;
                    acc_y[b.cidx] = b.ay;
                    acc_z[b.cidx] = b.az;
                end
                return;
            end
            p[0] = b.px; p[1] = b.py; p[2] = b.pz;
            v[0] = b.vx; v[1] = b.vy; v[2] = b.vz;
            // dead particle passes through
            if (!b.alive) begin
                r = '{b.px, b.py, b.pz, b.vx, b.vy, b.vz, 1'b0};
                pending.push_back(r);
                return;
            end
            // cell index and fraction per axis, clamped to the grid
            for (int k = 0; k < 3; k++) begin
                i = p[k] >>> FB;
                if (i < 0) i = 0;
                if (i > GD - 2) i = GD - 2;
                f[k] = p[k] - i * ONE;
                if (f[k] < 0) f[k] = 0;
                if (f[k] > ONE) f[k] = ONE;
                ix[k] = int'(i);
            end
            for (int k = 0; k < 3; k++) begin
                a = interp(k, ix, f);
                vn[k] = sat(v[k] + rnd_shift(a * dt, FB));
                pn[k] = p[k] + rnd_shift((v[k] + vn[k]) * dt, FB + 1);
            end
            ok = pn[0] >= xlo && pn[0] <= xhi && pn[1] >= ylo && pn[1] <= yhi;
            r.px = ok ? int'(sat(pn[0])) : b.px;
            r.py = ok ? int'(sat(pn[1])) : b.py;
            r.pz = ok ? int'(sat(pn[2])) : b.pz;
            r.vx = int'(vn[0]);
            r.vy = int'(vn[1]);
            r.vz = int'(vn[2]);
            r.alive = ok;
            pending.push_back(r);
        endfunction

        function void cmp(string name, longint e, longint g);
            if (e != g) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, g);
            end
        endfunction

        function void check(particle_t got);
            particle_t e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, got pos %0d %0d %0d", $time,
                         got.px, got.py, got.pz);
                return;
            end
            e = pending.pop_front();
            cmp("pos_out_x", e.px, got.px);
            cmp("pos_out_y", e.py, got.py);
            cmp("pos_out_z", e.pz, got.pz);
            cmp("vel_out_x", e.vx, got.vx);
            cmp("vel_out_y", e.vy, got.vy);
            cmp("vel_out_z", e.vz, got.vz);
            cmp("alive_out", e.alive, got.alive);
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0] i_cfg_data;
    logic i_valid, o_stall, i_mode, i_alive_in;
    logic [CELL_W-1:0] i_cell_index;
    logic signed [DATA_W-1:0] i_field_ax, i_field_ay, i_field_az;
    logic signed [DATA_W-1:0] i_pos_in_x, i_pos_in_y, i_pos_in_z;
    logic signed [DATA_W-1:0] i_vel_in_x, i_vel_in_y, i_vel_in_z;
    logic o_valid, i_stall, o_alive_out;
    logic signed [DATA_W-1:0] o_pos_out_x, o_pos_out_y, o_pos_out_z;
    logic signed [DATA_W-1:0] o_vel_out_x, o_vel_out_y, o_vel_out_z;

    particle_push_trilinear_field uut (.*);

    push_scoreboard sb;
    bit calm;
    bit hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_particle_push_trilinear_field: FAIL");
        $finish;
    end

    // receiver side: random stall bursts and one long hold-off
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall = 1'b1;
                repeat (80) @(negedge i_clk);
                hold_req = 1'b0;
                i_stall = 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                i_stall = 1'b1;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
                i_stall = 1'b0;
            end
        end
    end

    // result monitor
    initial begin
        particle_t got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got = '{o_pos_out_x, o_pos_out_y, o_pos_out_z,
                        o_vel_out_x, o_vel_out_y, o_vel_out_z, o_alive_out};
                sb.check(got);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] d);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = d;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_reg(idx, d);
    endtask

    // one input beat, then an optional idle burst
    task automatic send_beat(beat_t b);
        i_mode = b.mode;
        i_cell_index = b.cidx;
        i_field_ax = b.ax; i_field_ay = b.ay; i_field_az = b.az;
        i_pos_in_x = b.px; i_pos_in_y = b.py; i_pos_in_z = b.pz;
        i_vel_in_x = b.vx; i_vel_in_y = b.vy; i_vel_in_z = b.vz;
        i_alive_in = b.alive;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        sb.note(b);
        @(negedge i_clk);
        i_valid = 1'b0;
        if (!calm && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
    endtask

    // wait until every result is back, then let in-flight writes settle
    task automatic drain();
        i_valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic int rand_full();
        return int'($urandom);
    endfunction

    // a position whose cell lies next to the low or the high edge of its axis
    function automatic logic pos_ok(int p);
        return (p < 2 * ONE) || (p >= (GD - 3) * ONE);
    endfunction

    function automatic int rand_pos();
        int p;
        case ($urandom_range(0, 9))
            0: begin
                do p = rand_full(); while (!pos_ok(p));
            end
            1, 2:    p = int'($urandom_range(0, 2 * ONE)) - ONE + 15 * ONE;
            3:       p = int'($urandom_range(0, 2 * ONE)) - ONE;
            default: begin
                if ($urandom_range(0, 1))
                    p = int'($urandom_range(0, 7 * ONE / 2 - 1)) - 3 * ONE / 2;
                else
                    p = int'($urandom_range(0, 7 * ONE / 2)) + (GD - 3) * ONE;
            end
        endcase
        return p;
    endfunction

    function automatic int rand_vel();
        case ($urandom_range(0, 9))
            0:       return rand_full();
            1:       return $urandom_range(0, 1) ? INT_MAX - int'($urandom_range(0, 255))
                                                 : INT_MIN + int'($urandom_range(0, 255));
            default: return int'($urandom_range(0, 1 << 22)) - (1 << 21);
        endcase
    endfunction

    function automatic int rand_acc();
        if ($urandom_range(0, 7) == 0) return rand_full();
        return int'($urandom_range(0, 1 << 24)) - (1 << 23);
    endfunction

    function automatic beat_t make_write(int idx);
        beat_t b;
        b = '{MODE_WRITE, idx[CELL_W-1:0], rand_acc(), rand_acc(), rand_acc(),
              rand_full(), rand_full(), rand_full(), rand_full(), rand_full(),
              rand_full(), 1'($urandom)};
        return b;
    endfunction

    function automatic beat_t make_push();
        beat_t b;
        b = '{MODE_PUSH, CELL_W'($urandom), rand_full(), rand_full(), rand_full(),
              rand_pos(), rand_pos(), rand_pos(), rand_vel(), rand_vel(), rand_vel(),
              $urandom_range(0, 9) != 0};
        return b;
    endfunction

    function automatic beat_t push_at(int px, int py, int pz, int vx, int vy, int vz,
                                      logic alive);
        beat_t b;
        b = make_push();
        b.px = px; b.py = py; b.pz = pz;
        b.vx = vx; b.vy = vy; b.vz = vz;
        b.alive = alive;
        return b;
    endfunction

    task automatic set_phase(int ph);
        case (ph)
            0: begin
                write_reg(REG_TIME_STEP, DATA_W'(TIME_STEP_RST));
                write_reg(REG_BOUND_X_LOW, BOUND_X_LOW_RST);
                write_reg(REG_BOUND_X_HIGH, BOUND_X_HIGH_RST);
                write_reg(REG_BOUND_Y_LOW, BOUND_Y_LOW_RST);
                write_reg(REG_BOUND_Y_HIGH, BOUND_Y_HIGH_RST);
            end
            1: begin
                write_reg(REG_TIME_STEP, 32'h00ffffff);
                write_reg(REG_BOUND_X_LOW, INT_MIN);
                write_reg(REG_BOUND_X_HIGH, INT_MAX);
                write_reg(REG_BOUND_Y_LOW, INT_MIN);
                write_reg(REG_BOUND_Y_HIGH, INT_MAX);
                // unused index must leave all registers alone
                write_reg(REG_UNUSED, 32'h0);
            end
            2: begin
                write_reg(REG_TIME_STEP, 32'h0);
                write_reg(REG_BOUND_X_LOW, ONE);
                write_reg(REG_BOUND_X_HIGH, 14 * ONE);
                write_reg(REG_BOUND_Y_LOW, ONE);
                write_reg(REG_BOUND_Y_HIGH, 14 * ONE);
            end
            default: begin
                write_reg(REG_TIME_STEP, $urandom_range(1, 1 << 20));
                write_reg(REG_BOUND_X_LOW, int'($urandom_range(0, 2 * ONE)) - ONE);
                write_reg(REG_BOUND_X_HIGH, int'($urandom_range(10 * ONE, 17 * ONE)));
                write_reg(REG_BOUND_Y_LOW, int'($urandom_range(0, 2 * ONE)) - ONE);
                write_reg(REG_BOUND_Y_HIGH, int'($urandom_range(10 * ONE, 17 * ONE)));
            end
        endcase
    endtask

    // main sequence
    initial begin
        int sent;
        sb = new();
        calm = 1'b0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_mode = MODE_WRITE; i_cell_index = '0; i_alive_in = 1'b0;
        i_field_ax = '0; i_field_ay = '0; i_field_az = '0;
        i_pos_in_x = '0; i_pos_in_y = '0; i_pos_in_z = '0;
        i_vel_in_x = '0; i_vel_in_y = '0; i_vel_in_z = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        set_phase(0);

        // fill every cell that a push can read as a corner
        for (int x = 0; x < 6; x++)
            for (int y = 0; y < 6; y++)
                for (int z = 0; z < 6; z++)
                    send_beat(make_write((FILL_IX[x] * GD + FILL_IX[y]) * GD + FILL_IX[z]));

        // directed pushes: edges, extremes, dead particle, off-grid clamping
        send_beat(push_at(0, 0, 0, 0, 0, 0, 1'b1));
        send_beat(push_at(15 * ONE, 15 * ONE, 15 * ONE, 0, 0, 0, 1'b1));
        send_beat(push_at(INT_MIN, INT_MIN, INT_MIN, INT_MIN, INT_MIN, INT_MIN, 1'b1));
        send_beat(push_at(INT_MAX, INT_MAX, INT_MAX, INT_MAX, INT_MAX, INT_MAX, 1'b1));
        send_beat(push_at(-ONE / 2, 20 * ONE, (GD - 3) * ONE + 1, 100, -100, 5, 1'b1));
        send_beat(push_at(INT_MAX, INT_MIN, -1, INT_MAX, INT_MIN, -1, 1'b0));
        send_beat(push_at(ONE - 1, 2 * ONE - 1, 14 * ONE + ONE / 2, -ONE, ONE, 0, 1'b1));
        send_beat(make_write(GD * GD * GD - 1));
        send_beat(make_write(0));
        send_beat(push_at(15 * ONE - 1, ONE, 0, ONE, ONE, ONE, 1'b1));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            if (ph != 0) set_phase(ph);
            if (ph == 1) begin
                // overflow of position and velocity with the largest step
                send_beat(push_at(INT_MAX - ONE, ONE, INT_MAX - ONE,
                                  INT_MAX, 0, INT_MAX, 1'b1));
                send_beat(push_at(INT_MIN + ONE, ONE, INT_MIN + ONE,
                                  INT_MIN, 0, INT_MIN, 1'b1));
                send_beat(push_at(ONE, INT_MAX - 10, 14 * ONE, 0, INT_MAX, 0, 1'b1));
            end
            for (sent = 0; sent < 130; sent++) begin
                if (ph == 3 && sent == 70) calm = 1'b1;
                if (ph == 1 && sent == 40) hold_req = 1'b1;
                if (ph == 2 && sent == 60) begin
                    i_valid = 1'b0;
                    while (sb.pending.size() != 0) @(negedge i_clk);
                end
                if ($urandom_range(0, 6) == 0)
                    send_beat(make_write($urandom_range(0, STORE_DEPTH - 1)));
                else
                    send_beat(make_push());
            end
            drain();
        end

        repeat (30) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_particle_push_trilinear_field: PASS");
        else
            $display("tb_particle_push_trilinear_field: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
